### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers sampled on clk, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define SBDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication check
`define SBDA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// shared constants for the signed binary to decimal ascii converter
// ----------------------------------------------------------------------------
package sbda_pkg;

  // width of the value port and of one output character
  localparam int IN_WIDTH   = 64;
  localparam int CHAR_WIDTH = 7;

  // ascii codes
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'd45;

  // largest decimal digit value
  localparam logic [3:0] DIGIT_MAX = 4'd9;

endpackage

### sv/sbda_dabble.sv
// ----------------------------------------------------------------------------
// sbda_dabble
// one shift-add-3 step: corrects every bcd digit then shifts in one binary bit
// ----------------------------------------------------------------------------
module sbda_dabble #(
  parameter int VALUE_WIDTH = 64,
  parameter int NUM_DIGITS  = 19
) (
  input  logic [4*NUM_DIGITS-1:0] bcd_i,
  input  logic [VALUE_WIDTH-1:0]  bin_i,
  output logic [4*NUM_DIGITS-1:0] bcd_o,
  output logic [VALUE_WIDTH-1:0]  bin_o
);

  logic [4*NUM_DIGITS-1:0] adj;
  logic [3:0]              dig;

  // add 3 to each digit of 5 or more, lanes are independent
  always_comb begin
    adj = '0;
    dig = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig = bcd_i[4*i +: 4];
      if (dig >= 4'd5) begin
        adj[4*i +: 4] = dig + 4'd3;
      end else begin
        adj[4*i +: 4] = dig;
      end
    end
  end

  // shift the binary msb into the bcd lsb
  assign bcd_o = {adj[4*NUM_DIGITS-2:0], bin_i[VALUE_WIDTH-1]};
  assign bin_o = {bin_i[VALUE_WIDTH-2:0], 1'b0};

endmodule

### sv/signed_binary_to_decimal_ascii.sv
// Sequence: shift-add-3 conversion of the magnitude, then the sign step, then
// one step per decimal digit including skipped leading zeros.
// A new value is taken only in idle, once the last digit of the previous one has
// been issued; the single dabble unit steps one bit per cycle.
// Reset: synchronous active low rst_n returns the sequencer to idle and drops
// out_valid; no characters are pending after reset.
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// converts a signed integer to its decimal ascii text, one character per beat
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_binary_to_decimal_ascii import sbda_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IN_WIDTH-1:0]   in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_WIDTH-1:0] out_character,
  output logic                  out_last
);

  // digits of the largest magnitude, 2^(VALUE_WIDTH-1)
  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BW         = 4 * NUM_DIGITS;
  localparam int CW         = $clog2(VALUE_WIDTH + 1);
  localparam int DW         = $clog2(NUM_DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]  bin_r, bin_nxt;
  logic [BW-1:0]           bcd_r, bcd_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [DW-1:0]           dig_cnt_r, dig_cnt_nxt;
  logic                    neg_r, neg_nxt;
  logic                    started_r, started_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_WIDTH-1:0]   out_character_r, out_character_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [VALUE_WIDTH-1:0]  in_v;
  logic [BW-1:0]           bcd_step;
  logic [VALUE_WIDTH-1:0]  bin_step;
  logic [3:0]              top_dig;
  logic                    out_free;

  // shared conversion unit
  sbda_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_dabble (
    .bcd_i (bcd_r),
    .bin_i (bin_r),
    .bcd_o (bcd_step),
    .bin_o (bin_step)
  );

  assign in_v     = in_value[VALUE_WIDTH-1:0];
  assign top_dig  = bcd_r[BW-1 -: 4];
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // sequencer next state
  always_comb begin
    state_nxt         = state_r;
    bin_nxt           = bin_r;
    bcd_nxt           = bcd_r;
    cnt_nxt           = cnt_r;
    dig_cnt_nxt       = dig_cnt_r;
    neg_nxt           = neg_r;
    started_nxt       = started_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_v[VALUE_WIDTH-1];
          bin_nxt   = in_v[VALUE_WIDTH-1] ? (~in_v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : in_v;
          bcd_nxt   = '0;
          cnt_nxt   = CW'(VALUE_WIDTH);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = bcd_step;
        bin_nxt = bin_step;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          dig_cnt_nxt = DW'(NUM_DIGITS);
          started_nxt = 1'b0;
          state_nxt   = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!neg_r) begin
          state_nxt = ST_DIGIT;
        end else if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = CHAR_MINUS;
          out_last_nxt      = 1'b0;
          state_nxt         = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (top_dig == 4'd0 && !started_r && dig_cnt_r > DW'(1)) begin
          // leading zero, drop it
          bcd_nxt     = {bcd_r[BW-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = CHAR_ZERO + {3'd0, top_dig};
          out_last_nxt      = (dig_cnt_r == DW'(1));
          bcd_nxt           = {bcd_r[BW-5:0], 4'd0};
          dig_cnt_nxt       = dig_cnt_r - 1'b1;
          started_nxt       = 1'b1;
          if (dig_cnt_r == DW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
    bin_r           <= bin_nxt;
    bcd_r           <= bcd_nxt;
    cnt_r           <= cnt_nxt;
    dig_cnt_r       <= dig_cnt_nxt;
    neg_r           <= neg_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  // a pending non-final character means more digits of this number follow
  `SBDA_ASSERT_IMP(a_mid_beat_in_digits, out_valid_r && !out_last_r, state_r == ST_DIGIT, "non-final beat outside digit phase")
  // every character is a minus sign or a decimal digit
  `SBDA_ASSERT_IMP(a_char_code, out_valid_r, (out_character_r == CHAR_MINUS) || ((out_character_r >= CHAR_ZERO) && (out_character_r <= CHAR_ZERO + {3'd0, DIGIT_MAX})), "bad character code")
  // conversion ends only after the last bit step
  `SBDA_ASSERT(a_conv_length, !(state_r == ST_SIGN && $past(state_r) == ST_CONV) || ($past(cnt_r) == CW'(1)), "conversion left early")

endmodule

### verif/tb_signed_binary_to_decimal_ascii.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_binary_to_decimal_ascii
// self-checking bench for the signed integer to decimal ascii converter:
// values go in one beat at a time, every character beat coming back is
// checked against text predicted in the bench, under random idle and stall
// ----------------------------------------------------------------------------
module tb_signed_binary_to_decimal_ascii;
  import sbda_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 100;
  localparam int MAX_DIGITS     = 19;

  // one expected character beat
  typedef struct packed {
    logic [CHAR_WIDTH-1:0] ch;
    logic                  last;
  } ascii_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [IN_WIDTH-1:0]   in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_WIDTH-1:0] out_character;
  logic                  out_last;

  ascii_beat_t expected_text[$];
  ascii_beat_t want_beat;
  int          error_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  signed_binary_to_decimal_ascii #(
    .VALUE_WIDTH(IN_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #2 clk = ~clk;

  // mismatch reporting
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // decimal text of one value, sign first, most significant digit first
  function automatic void predict_text(input logic [IN_WIDTH-1:0] v);
    logic [3:0]          digs[MAX_DIGITS];
    logic [IN_WIDTH-1:0] mag;
    logic                neg;
    int                  nd;
    ascii_beat_t         b;
    neg = v[IN_WIDTH-1];
    // the most negative value negates to itself, which is right unsigned
    mag = neg ? (~v + 1'b1) : v;
    nd = 0;
    do begin
      digs[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end while (mag != 0 && nd < MAX_DIGITS);
    if (neg) begin
      b.ch = CHAR_MINUS;
      b.last = 1'b0;
      expected_text.push_back(b);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      b.ch = CHAR_ZERO + CHAR_WIDTH'(digs[i]);
      b.last = (i == 0);
      expected_text.push_back(b);
    end
  endfunction

  // random value, biased toward every digit count and decade edges
  function automatic logic [IN_WIDTH-1:0] rand_value();
    logic [IN_WIDTH-1:0] r;
    int                  nbits;
    int                  kind;
    r = {$urandom, $urandom};
    kind = $urandom_range(9);
    if (kind < 2) begin
      r = 1;
      repeat ($urandom_range(18)) r = r * 10;
      r = r + IN_WIDTH'($urandom_range(2)) - 1'b1;
    end else if (kind < 7) begin
      nbits = $urandom_range(1, IN_WIDTH);
      if (nbits < IN_WIDTH) r = r & ((64'd1 << nbits) - 1);
    end
    if (kind < 7 && $urandom_range(1) == 1) r = ~r + 1'b1;
    return r;
  endfunction

  // one value beat; called and returns at a falling edge
  task automatic send_value(input logic [IN_WIDTH-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_text(v);
    @(negedge clk);
  endtask

  // drop valid and hold off until all pending text has come back
  task automatic drain_text();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(negedge clk);
  endtask

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // check each accepted character beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected beat char=0x%02h last=%0b",
                                  out_character, out_last));
      end else begin
        want_beat = expected_text.pop_front();
        if (out_character !== want_beat.ch)
          report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                    out_character, want_beat.ch));
        if (out_last !== want_beat.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, want_beat.last));
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a beat", WATCHDOG_LIMIT);
      $display("signed_binary_to_decimal_ascii regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // extremes, zero, signs and the most negative value
  task automatic test_extremes();
    send_value(64'd0);
    send_value(64'd1);
    send_value(-64'sd1);
    send_value(64'd9);
    send_value(-64'sd9);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h8000_0000_0000_0001);
    send_value(64'h5555_5555_5555_5555);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  // decade edges, where the digit count changes
  task automatic test_decade_edges();
    send_value(64'd10);
    send_value(-64'sd10);
    send_value(64'd99);
    send_value(64'd100);
    send_value(64'd999_999_999_999_999_999);
    send_value(64'd1_000_000_000_000_000_000);
    send_value(-64'sd1_000_000_000_000_000_000);
    send_value(64'd1_234_567_890);
    send_value(-64'sd9_876_543_210);
    send_value(64'h0123_4567_89AB_CDEF);
  endtask

  // sender holds off until every pending character has arrived
  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++) begin
      send_value(rand_value());
      if (i % 3 == 2) drain_text();
    end
  endtask

  // random values under one idle and stall setting
  task automatic test_random(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_value(rand_value());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 9;
    recv_stall_pct = 69;
    test_extremes();
    test_decade_edges();
    test_drain_pause();
    test_random(9, 69, 48);
    test_random(69, 9, 48);
    test_random(0, 0, 48);

    // wind down
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_text.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));

    if (error_count == 0) begin
      $display("signed_binary_to_decimal_ascii regression: pass");
    end else begin
      $display("signed_binary_to_decimal_ascii regression: fail");
    end
    $finish;
  end

endmodule
